// File: sv/greedy_random_independent_set_macros.svh
// Assertion macros for the greedy random independent set block.
// Used by the top level; no other dependencies.
`ifndef GREEDY_RANDOM_INDEPENDENT_SET_MACROS_SVH
`define GREEDY_RANDOM_INDEPENDENT_SET_MACROS_SVH
`ifndef SYNTHESIS
`define GRIS_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GRIS_ASSERT_NEXT(name, clk, rst_n, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define GRIS_ASSERT(name, clk, rst_n, prop, msg)
`define GRIS_ASSERT_NEXT(name, clk, rst_n, pre, post, msg)
`endif
`endif

// File: sv/gris_pkg.sv
// Shared types and constants of the greedy random independent set block.
// No dependencies.
package gris_pkg;

  localparam int DEG_W = 8;
  localparam logic [DEG_W-1:0] DEG_MAX = 8'hFF;

  // input actions
  localparam logic [1:0] ACT_CLEAR   = 2'd0;
  localparam logic [1:0] ACT_EDGE    = 2'd1;
  localparam logic [1:0] ACT_SELECT  = 2'd2;
  localparam logic [1:0] ACT_RESTART = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_VCOUNT = 2'd0;
  localparam logic [1:0] REG_DETLVL = 2'd1;
  localparam logic [1:0] REG_ALPHA  = 2'd2;

  // control from the sequencer to the ranking unit
  typedef struct packed {
    logic start;       // new select: drop threshold and best
    logic next;        // next pass: best becomes threshold
    logic cand_valid;  // a live candidate is on the inputs
  } rank_ctl_t;

endpackage

// File: sv/gris_mod.sv
// Restoring modulo unit: one quotient bit per cycle.
// Depends on nothing but its ports.
module gris_mod (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [30:0] dividend_i,
  input  logic [6:0]  divisor_i,
  output logic        done_o,
  output logic [6:0]  rem_o
);

  logic [30:0] dvd_q, dvd_d;
  logic [6:0]  rem_q, rem_d, dsr_q, dsr_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [7:0]  trial;

  // shift in one dividend bit, subtract when it fits
  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, dvd_q[30]};
    if (start_i) begin
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dsr_q}) begin
        trial = trial - {1'b0, dsr_q};
      end
      rem_d = trial[6:0];
      dvd_d = {dvd_q[29:0], 1'b0};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd30) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// File: sv/gris_rank.sv
// Ranking unit: keeps the least (degree, index) pair above a threshold pair.
// Depends on gris_pkg.
module gris_rank
  import gris_pkg::*;
#(
  parameter int VW = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rank_ctl_t        ctl_i,
  input  logic [DEG_W-1:0] cand_deg_i,
  input  logic [VW-1:0]    cand_idx_i,
  output logic [VW-1:0]    best_idx_o,
  output logic             found_o
);

  logic [DEG_W-1:0] best_deg_q, thr_deg_q;
  logic [VW-1:0]    best_idx_q, thr_idx_q;
  logic             found_q, has_thr_q;
  logic             eligible, better;

  // candidate must rank above the threshold and below the current best
  always_comb begin
    eligible = !has_thr_q || (cand_deg_i > thr_deg_q) ||
               ((cand_deg_i == thr_deg_q) && (cand_idx_i > thr_idx_q));
    better   = !found_q || (cand_deg_i < best_deg_q) ||
               ((cand_deg_i == best_deg_q) && (cand_idx_i < best_idx_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q   <= 1'b0;
      has_thr_q <= 1'b0;
    end else if (ctl_i.start) begin
      found_q   <= 1'b0;
      has_thr_q <= 1'b0;
    end else if (ctl_i.next) begin
      found_q   <= 1'b0;
      has_thr_q <= 1'b1;
    end else if (ctl_i.cand_valid && eligible && better) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.next) begin
      thr_deg_q <= best_deg_q;
      thr_idx_q <= best_idx_q;
    end else if (!ctl_i.start && ctl_i.cand_valid && eligible && better) begin
      best_deg_q <= cand_deg_i;
      best_idx_q <= cand_idx_i;
    end
  end

  assign best_idx_o = best_idx_q;
  assign found_o    = found_q;

endmodule

// File: sv/greedy_random_independent_set.sv
// Greedy random independent set builder. Edge words fill an adjacency memory and
// a degree memory. A select word streams the degrees of the first n vertices one
// per cycle through the shared ranking unit, with removed ones masked, and the
// m-th pass yields the vertex. A deterministic pick uses m = 1. A random pick
// first runs a 31-step modulo and waits for it, then goes through a next-pass
// state between passes, with m = k - pick mod k. A select that finds no vertex
// left returns a finished word. Every select also holds in its last cycle while
// the previous result word is stalled. Add edge reads and writes both end rows;
// restart clears the removed set. Clear graph and reset each run a clearing pass
// over all MAX_VERTICES entries of both memories, during which no word is taken;
// configuration writes are always taken.
// Depends on gris_pkg, gris_rank, gris_mod and the assertion macro header.
`include "greedy_random_independent_set_macros.svh"
module greedy_random_independent_set
  import gris_pkg::*;
#(
  parameter int MAX_VERTICES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [5:0]  vertex_a_i,
  input  logic [5:0]  vertex_b_i,
  input  logic [6:0]  rand_percent_i,
  input  logic [30:0] rand_pick_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [5:0]  chosen_vertex_o,
  output logic        finished_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [6:0]  cfg_data_i
);

  localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = (VW > 7) ? VW + 1 : 8;
  localparam logic [MAX_VERTICES-1:0] ROW_ONE = MAX_VERTICES'(1);

  typedef enum logic [12:0] {
    S_CLR    = 13'b0000000000001,
    S_IDLE   = 13'b0000000000010,
    S_EA_RD  = 13'b0000000000100,
    S_EA_WR  = 13'b0000000001000,
    S_EB_RD  = 13'b0000000010000,
    S_EB_WR  = 13'b0000000100000,
    S_SCAN   = 13'b0000001000000,
    S_DECIDE = 13'b0000010000000,
    S_DIV    = 13'b0000100000000,
    S_NEXT   = 13'b0001000000000,
    S_RM_RD  = 13'b0010000000000,
    S_RM_UPD = 13'b0100000000000,
    S_OUT    = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [6:0] vcount_q, detlvl_q, alpha_q;

  // memories
  logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
  logic [DEG_W-1:0]        deg_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] adj_rd_q, adj_wd;
  logic [DEG_W-1:0]        deg_rd_q, deg_wd;
  logic [VW-1:0]           adj_ra, adj_wa, deg_ra, deg_wa;
  logic                    adj_we, deg_we;

  // sequencer registers
  logic [CW-1:0]           cnt_q, cnt_d;
  logic [MAX_VERTICES-1:0] removed_q, removed_d;
  logic [5:0]              ea_q, eb_q, ea_d, eb_d;
  logic [6:0]              n_q, n_d, pct_q, pct_d, live_q, live_d;
  logic [6:0]              k_q, k_d, left_q, left_d;
  logic [30:0]             pick_q, pick_d;
  logic                    pend_q, pend_d, first_q, first_d, fin_q, fin_d;
  logic [VW-1:0]           pend_idx_q, pend_idx_d, chosen_q, chosen_d;
  logic                    out_valid_q, out_valid_d, out_fin_q, out_fin_d;
  logic [5:0]              out_vtx_q, out_vtx_d;

  // shared units
  rank_ctl_t     rank_ctl;
  logic [VW-1:0] best_idx;
  logic          rank_found;
  logic          mod_start, mod_done;
  logic [6:0]    mod_rem;

  logic          in_acc, edge_ok, scan_done;
  logic [6:0]    alpha_eff, k_cand, m_val;
  logic [CW-1:0] n_ext;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign edge_ok     = (int'(vertex_a_i) < MAX_VERTICES) && (int'(vertex_b_i) < MAX_VERTICES);
  assign n_ext       = CW'(n_q);
  assign scan_done   = (cnt_q >= n_ext) && !pend_q;
  assign alpha_eff   = (alpha_q == 7'd0) ? 7'd1 : alpha_q;
  assign k_cand      = (alpha_eff < live_q) ? alpha_eff : live_q;
  assign m_val       = k_q - mod_rem;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= 7'd0;
      detlvl_q <= 7'd100;
      alpha_q  <= 7'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_VCOUNT: vcount_q <= cfg_data_i;
        REG_DETLVL: detlvl_q <= cfg_data_i;
        REG_ALPHA:  alpha_q  <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  // memory port selection
  always_comb begin
    adj_we = 1'b0;
    deg_we = 1'b0;
    adj_wa = VW'(ea_q);
    deg_wa = VW'(ea_q);
    adj_wd = '0;
    deg_wd = '0;
    adj_ra = '0;
    deg_ra = '0;
    case (state_q)
      S_CLR: begin
        adj_we = 1'b1;
        deg_we = 1'b1;
        adj_wa = cnt_q[VW-1:0];
        deg_wa = cnt_q[VW-1:0];
      end
      S_EA_RD: begin
        adj_ra = VW'(ea_q);
        deg_ra = VW'(ea_q);
      end
      S_EA_WR: begin
        adj_we = 1'b1;
        deg_we = 1'b1;
        adj_wd = adj_rd_q | (ROW_ONE << eb_q);
        deg_wd = (deg_rd_q == DEG_MAX) ? deg_rd_q : deg_rd_q + 8'd1;
      end
      S_EB_RD: begin
        adj_ra = VW'(eb_q);
        deg_ra = VW'(eb_q);
      end
      S_EB_WR: begin
        adj_we = 1'b1;
        deg_we = 1'b1;
        adj_wa = VW'(eb_q);
        deg_wa = VW'(eb_q);
        adj_wd = adj_rd_q | (ROW_ONE << ea_q);
        deg_wd = (deg_rd_q == DEG_MAX) ? deg_rd_q : deg_rd_q + 8'd1;
      end
      S_SCAN:  deg_ra = cnt_q[VW-1:0];
      S_RM_RD: adj_ra = best_idx;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adj_we) begin
      adj_mem[adj_wa] <= adj_wd;
    end
    adj_rd_q <= adj_mem[adj_ra];
  end

  always_ff @(posedge clk_i) begin
    if (deg_we) begin
      deg_mem[deg_wa] <= deg_wd;
    end
    deg_rd_q <= deg_mem[deg_ra];
  end

  // ranking unit control
  always_comb begin
    rank_ctl.start      = in_acc && (action_i == ACT_SELECT);
    rank_ctl.next       = (state_q == S_NEXT);
    rank_ctl.cand_valid = (state_q == S_SCAN) && pend_q && !removed_q[pend_idx_q];
  end

  gris_rank #(
    .VW (VW)
  ) u_rank (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (rank_ctl),
    .cand_deg_i (deg_rd_q),
    .cand_idx_i (pend_idx_q),
    .best_idx_o (best_idx),
    .found_o    (rank_found)
  );

  assign mod_start = (state_q == S_DECIDE) && (live_q != 7'd0) && (pct_q > detlvl_q);

  gris_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (pick_q),
    .divisor_i  (k_cand),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    removed_d   = removed_q;
    ea_d        = ea_q;
    eb_d        = eb_q;
    n_d         = n_q;
    pct_d       = pct_q;
    pick_d      = pick_q;
    live_d      = live_q;
    k_d         = k_q;
    left_d      = left_q;
    pend_d      = pend_q;
    pend_idx_d  = pend_idx_q;
    first_d     = first_q;
    fin_d       = fin_q;
    chosen_d    = chosen_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_vtx_d   = out_vtx_q;
    out_fin_d   = out_fin_q;
    case (state_q)
      S_CLR: begin
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(MAX_VERTICES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          case (action_i)
            ACT_CLEAR: begin
              removed_d = '0;
              cnt_d     = '0;
              state_d   = S_CLR;
            end
            ACT_EDGE: begin
              ea_d = vertex_a_i;
              eb_d = vertex_b_i;
              if (edge_ok) begin
                state_d = S_EA_RD;
              end
            end
            ACT_SELECT: begin
              n_d     = (int'(vcount_q) > MAX_VERTICES) ? 7'(MAX_VERTICES) : vcount_q;
              pct_d   = rand_percent_i;
              pick_d  = rand_pick_i;
              cnt_d   = '0;
              pend_d  = 1'b0;
              first_d = 1'b1;
              live_d  = '0;
              state_d = S_SCAN;
            end
            ACT_RESTART: removed_d = '0;
            default: ;
          endcase
        end
      end
      S_EA_RD: state_d = S_EA_WR;
      S_EA_WR: state_d = S_EB_RD;
      S_EB_RD: state_d = S_EB_WR;
      S_EB_WR: state_d = S_IDLE;
      S_SCAN: begin
        // issue one degree read a cycle; compare the one that returned
        if (cnt_q < n_ext) begin
          pend_d     = 1'b1;
          pend_idx_d = cnt_q[VW-1:0];
          cnt_d      = cnt_q + CW'(1);
        end else begin
          pend_d = 1'b0;
        end
        if (first_q && rank_ctl.cand_valid) begin
          live_d = live_q + 7'd1;
        end
        if (scan_done) begin
          if (first_q) begin
            state_d = S_DECIDE;
          end else if (left_q == 7'd1) begin
            state_d = S_RM_RD;
          end else begin
            left_d  = left_q - 7'd1;
            state_d = S_NEXT;
          end
        end
      end
      S_DECIDE: begin
        k_d = k_cand;
        if (live_q == 7'd0) begin
          fin_d    = 1'b1;
          chosen_d = '0;
          state_d  = S_OUT;
        end else if (pct_q <= detlvl_q) begin
          state_d = S_RM_RD;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (mod_done) begin
          left_d  = m_val - 7'd1;
          state_d = (m_val == 7'd1) ? S_RM_RD : S_NEXT;
        end
      end
      S_NEXT: begin
        cnt_d   = '0;
        pend_d  = 1'b0;
        first_d = 1'b0;
        state_d = S_SCAN;
      end
      S_RM_RD: begin
        chosen_d = best_idx;
        state_d  = S_RM_UPD;
      end
      S_RM_UPD: begin
        // drop the chosen vertex and all its neighbors
        removed_d = removed_q | adj_rd_q | (ROW_ONE << chosen_q);
        fin_d     = 1'b0;
        state_d   = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_vtx_d   = 6'(chosen_q);
          out_fin_d   = fin_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      cnt_q       <= '0;
      removed_q   <= '0;
      pend_q      <= 1'b0;
      first_q     <= 1'b0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      removed_q   <= removed_d;
      pend_q      <= pend_d;
      first_q     <= first_d;
      left_q      <= left_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ea_q       <= ea_d;
    eb_q       <= eb_d;
    n_q        <= n_d;
    pct_q      <= pct_d;
    pick_q     <= pick_d;
    live_q     <= live_d;
    k_q        <= k_d;
    pend_idx_q <= pend_idx_d;
    fin_q      <= fin_d;
    chosen_q   <= chosen_d;
    out_vtx_q  <= out_vtx_d;
    out_fin_q  <= out_fin_d;
  end

  assign out_valid_o     = out_valid_q;
  assign chosen_vertex_o = out_vtx_q;
  assign finished_o      = out_fin_q;

  `GRIS_ASSERT(a_fin_zero, clk_i, rst_ni, out_valid_o && finished_o |-> chosen_vertex_o == 6'd0, "finished word carries a nonzero vertex")
  `GRIS_ASSERT(a_mod_in_div, clk_i, rst_ni, mod_done |-> state_q == S_DIV, "modulo result outside its wait state")
  `GRIS_ASSERT(a_pick_found, clk_i, rst_ni, state_q == S_RM_RD |-> rank_found, "removal started without a ranked vertex")
  `GRIS_ASSERT_NEXT(a_chosen_gone, clk_i, rst_ni, state_q == S_RM_UPD, removed_q[chosen_q], "chosen vertex not removed")

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for the greedy random independent set builder.
// Runs directed and random edge, select, clear and restart words against a
// behavioral predictor of the block. Depends on gris_pkg and the block itself.
module tb_top
  import gris_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0]  action;
    logic [5:0]  va;
    logic [5:0]  vb;
    logic [6:0]  pct;
    logic [30:0] pick;
  } gris_word_t;

  typedef struct {
    logic [5:0] vertex;
    logic       done;
  } pick_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  action_i = ACT_CLEAR;
  logic [5:0]  vertex_a_i = '0;
  logic [5:0]  vertex_b_i = '0;
  logic [6:0]  rand_percent_i = '0;
  logic [30:0] rand_pick_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [5:0]  chosen_vertex_o;
  logic        finished_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = REG_VCOUNT;
  logic [6:0]  cfg_data_i = '0;

  greedy_random_independent_set u_top (.*);

  always #6 clk_i = ~clk_i;

  // predictor state and configuration copy
  logic [63:0] adj_rows [64];
  logic [7:0]  degree [64];
  logic [63:0] removed_set;
  logic [6:0]  vcount_reg = 7'd0;
  logic [6:0]  detlvl_reg = 7'd100;
  logic [6:0]  alpha_reg = 7'd1;

  gris_word_t   pending_words[$];
  pick_result_t expected_picks[$];
  int  error_count = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  pressure_req = 0;
  bit  pressure_used = 0;
  int  hold_left = 0;
  int  word_total = 0;

  initial begin
    for (int i = 0; i < 64; i++) begin
      adj_rows[i] = '0;
      degree[i] = '0;
    end
    removed_set = '0;
  end

  // advance the predictor by one accepted word
  task automatic predict_word(gris_word_t w);
    int n, alpha, live, k, m, below;
    int chosen;
    bit found;
    pick_result_t r;
    case (w.action)
      ACT_CLEAR: begin
        for (int i = 0; i < 64; i++) begin
          adj_rows[i] = '0;
          degree[i] = '0;
        end
        removed_set = '0;
      end
      ACT_EDGE: begin
        adj_rows[w.va][w.vb] = 1'b1;
        adj_rows[w.vb][w.va] = 1'b1;
        if (degree[w.va] != DEG_MAX) degree[w.va]++;
        if (degree[w.vb] != DEG_MAX) degree[w.vb]++;
      end
      ACT_RESTART: removed_set = '0;
      default: begin
        n = (vcount_reg > 64) ? 64 : vcount_reg;
        alpha = (alpha_reg == 0) ? 1 : alpha_reg;
        live = 0;
        for (int v = 0; v < n; v++) if (!removed_set[v]) live++;
        if (live == 0) begin
          r.vertex = '0;
          r.done = 1'b1;
        end else begin
          k = (alpha < live) ? alpha : live;
          m = (w.pct <= detlvl_reg) ? 1 : k - int'(w.pick % k);
          chosen = 0;
          found = 0;
          for (int v = 0; v < n && !found; v++) begin
            if (!removed_set[v]) begin
              below = 0;
              for (int i = 0; i < n; i++)
                if (!removed_set[i] && (degree[i] < degree[v] ||
                    (degree[i] == degree[v] && i < v)))
                  below++;
              if (below == m - 1) begin
                chosen = v;
                found = 1;
              end
            end
          end
          removed_set = removed_set | adj_rows[chosen];
          removed_set[chosen] = 1'b1;
          r.vertex = chosen[5:0];
          r.done = 1'b0;
        end
        expected_picks.insert(expected_picks.size(), r);
      end
    endcase
  endtask

  // driver: advance on acceptance, hold while stalled
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o)
        predict_word('{action_i, vertex_a_i, vertex_b_i, rand_percent_i, rand_pick_i});
      if (!in_valid_i || !in_stall_o) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          gris_word_t w;
          w = pending_words.pop_front();
          action_i <= w.action;
          vertex_a_i <= w.va;
          vertex_b_i <= w.vb;
          rand_percent_i <= w.pct;
          rand_pick_i <= w.pick;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: check each accepted result word, drive random stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_picks.size() == 0) begin
          $error("unexpected result word: chosen_vertex %0d finished %0d",
                 chosen_vertex_o, finished_o);
          error_count++;
        end else begin
          pick_result_t r;
          r = expected_picks.pop_front();
          if (chosen_vertex_o !== r.vertex) begin
            $error("chosen_vertex expected %0d actual %0d", r.vertex, chosen_vertex_o);
            error_count++;
          end
          if (finished_o !== r.done) begin
            $error("finished expected %0d actual %0d", r.done, finished_o);
            error_count++;
          end
        end
      end
      if (pressure_req && !pressure_used) begin
        pressure_used <= 1'b1;
        hold_left <= 600;
        out_stall_i <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  task automatic cfg_write(logic [1:0] idx, logic [6:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_VCOUNT: vcount_reg = data;
      REG_DETLVL: detlvl_reg = data;
      default:    alpha_reg = data;
    endcase
  endtask

  task automatic push_word(logic [1:0] act, int a, int b, int pct, logic [30:0] pick);
    gris_word_t w;
    w = '{act, a[5:0], b[5:0], pct[6:0], pick};
    pending_words.insert(pending_words.size(), w);
    word_total++;
  endtask

  // hold until all words are taken and all results checked, then let it settle
  task automatic drain();
    while (pending_words.size() > 0 || in_valid_i || expected_picks.size() > 0)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic set_config(int vc, int dl, int al);
    cfg_write(REG_VCOUNT, vc[6:0]);
    cfg_write(REG_DETLVL, dl[6:0]);
    cfg_write(REG_ALPHA, al[6:0]);
  endtask

  initial begin
    int phase, n, edges, hi;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty graph, self loop, duplicates, out-of-range, restart, clear
    send_idle_pct = 13;
    recv_idle_pct = 50;
    push_word(ACT_SELECT, 0, 0, 50, 0);
    drain();
    set_config(4, 0, 0);
    push_word(ACT_EDGE, 0, 1, 0, 0);
    push_word(ACT_EDGE, 1, 2, 0, 0);
    push_word(ACT_EDGE, 1, 2, 0, 0);
    push_word(ACT_EDGE, 3, 3, 0, 0);
    push_word(ACT_EDGE, 63, 62, 0, 0);
    push_word(ACT_SELECT, 0, 0, 1, 31'h7FFF_FFFF);
    push_word(ACT_SELECT, 0, 0, 127, 31'h7FFF_FFFF);
    push_word(ACT_SELECT, 0, 0, 0, 0);
    push_word(ACT_RESTART, 0, 0, 0, 0);
    push_word(ACT_SELECT, 0, 0, 100, 0);
    push_word(ACT_CLEAR, 0, 0, 0, 0);
    push_word(ACT_SELECT, 0, 0, 100, 0);
    drain();
    set_config(64, 100, 64);
    push_word(ACT_EDGE, 5, 63, 0, 0);
    push_word(ACT_SELECT, 0, 0, 101, 31'h5555_5555);
    push_word(ACT_SELECT, 0, 0, 127, 0);
    push_word(ACT_RESTART, 0, 0, 0, 0);
    drain();
    set_config(127, 127, 127);
    for (int i = 0; i < 255 + 4; i++) push_word(ACT_EDGE, 7, 7, 0, 0);
    push_word(ACT_SELECT, 0, 0, 127, 31'h2AAA_AAAA);
    push_word(ACT_SELECT, 0, 0, 127, 3);
    push_word(ACT_CLEAR, 0, 0, 0, 0);
    drain();

    // random phases: build a graph, select until done, restart, some noise
    phase = 0;
    while (word_total < 1650) begin
      if (word_total < 600) begin
        send_idle_pct = 13;
        recv_idle_pct = 50;
      end else if (word_total < 1150) begin
        send_idle_pct = 50;
        recv_idle_pct = 13;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      n = ($urandom_range(9) == 0) ? $urandom_range(64, 127) : $urandom_range(1, 16);
      hi = (n > 64) ? 63 : n - 1;
      set_config(n, ($urandom_range(5) == 0) ? $urandom_range(101, 127) :
                 $urandom_range(0, 100),
                 (n >= 64) ? $urandom_range(0, 4) :
                 ($urandom_range(7) == 0) ? 127 : $urandom_range(0, n + 1));
      if (phase == 1) pressure_req = 1;
      push_word(ACT_CLEAR, $urandom_range(63), $urandom_range(63), 0, 0);
      edges = $urandom_range(0, 2 * (hi + 1));
      for (int e = 0; e < edges; e++) begin
        if ($urandom_range(9) == 0)
          push_word(ACT_EDGE, $urandom_range(63), $urandom_range(63), 0, 0);
        else
          push_word(ACT_EDGE, $urandom_range(hi), $urandom_range(hi), 0, 0);
      end
      for (int r = 0; r < 2; r++) begin
        for (int s = 0; s <= ((hi + 2 < 18) ? hi + 2 : 18); s++) begin
          if ($urandom_range(9) == 0)
            push_word(2'($urandom_range(3)), $urandom_range(63), $urandom_range(63),
                      $urandom_range(127), 31'($urandom()));
          push_word(ACT_SELECT, $urandom_range(63), $urandom_range(63),
                    ($urandom_range(9) == 0) ? $urandom_range(127) :
                    $urandom_range(1, 100), 31'($urandom()));
        end
        push_word(ACT_RESTART, $urandom_range(63), $urandom_range(63), 0, 0);
      end
      drain();
      phase++;
    end

    if (error_count == 0) begin
      $display("[greedy_random_independent_set] OK");
    end else begin
      $display("[greedy_random_independent_set] ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #200ms;
    $display("[greedy_random_independent_set] ERROR");
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/gris_pkg.sv
sv/gris_mod.sv
sv/gris_rank.sv
sv/greedy_random_independent_set.sv
dv/tb_top.sv
